// File: src/yrc_pkg.sv
// Shared types, constants and byte-order table for the YUV 4:2:2 to RGB888 converter.
package yrc_pkg;

   // Fixed-point scaling
   localparam int FX_SHIFT = 20;
   localparam int PROD_W   = 31;   // signed product width
   localparam int TERM_W   = 29;   // floored, nonnegative luma/chroma term
   localparam int SUM_W    = 30;   // luma + chroma

   // BT.601 video-range coefficients, 20-bit fraction
   localparam logic signed [PROD_W-1:0] K_Y  = 31'sd1220542;
   localparam logic signed [PROD_W-1:0] K_RV = 31'sd1673527;
   localparam logic signed [PROD_W-1:0] K_GV = -31'sd852492;
   localparam logic signed [PROD_W-1:0] K_GU = -31'sd409993;
   localparam logic signed [PROD_W-1:0] K_BU = 31'sd2116026;

   localparam logic signed [8:0] Y_OFFSET = 9'sd16;
   localparam logic signed [8:0] C_OFFSET = 9'sd128;
   localparam logic [7:0]        CH_MAX   = 8'd255;

   // Byte packings
   typedef enum logic [2:0] {
      ORDER_YUYV = 3'd0,
      ORDER_UYVY = 3'd1,
      ORDER_VYUY = 3'd2,
      ORDER_YVYU = 3'd3,
      ORDER_UVY2 = 3'd4,
      ORDER_VUY2 = 3'd5,
      ORDER_Y2UV = 3'd6,
      ORDER_Y2VU = 3'd7
   } byte_order_type;

   // Byte positions of Y0, Y1, U and V for one packing
   typedef struct packed {
      logic [1:0] pos_y0;
      logic [1:0] pos_y1;
      logic [1:0] pos_u;
      logic [1:0] pos_v;
   } pick_type;

   function automatic pick_type pick_lookup(input byte_order_type order);
      pick_type p;
      case (order)
         ORDER_YUYV: p = '{2'd0, 2'd2, 2'd1, 2'd3};
         ORDER_UYVY: p = '{2'd1, 2'd3, 2'd0, 2'd2};
         ORDER_VYUY: p = '{2'd1, 2'd3, 2'd2, 2'd0};
         ORDER_YVYU: p = '{2'd0, 2'd2, 2'd3, 2'd1};
         ORDER_UVY2: p = '{2'd3, 2'd1, 2'd0, 2'd2};
         ORDER_VUY2: p = '{2'd3, 2'd1, 2'd2, 2'd0};
         ORDER_Y2UV: p = '{2'd2, 2'd0, 2'd1, 2'd3};
         ORDER_Y2VU: p = '{2'd2, 2'd0, 2'd3, 2'd1};
         default:    p = '{2'd0, 2'd2, 2'd1, 2'd3};
      endcase
      return p;
   endfunction

   // Input item
   typedef struct packed {
      logic [7:0] byte_0;
      logic [7:0] byte_1;
      logic [7:0] byte_2;
      logic [7:0] byte_3;
      logic       frame_end_in;
   } req_type;

   // Result item
   typedef struct packed {
      logic [7:0] red_first;
      logic [7:0] green_first;
      logic [7:0] blue_first;
      logic [7:0] red_second;
      logic [7:0] green_second;
      logic [7:0] blue_second;
      logic       frame_end_out;
   } rsp_type;

   // Floored chroma terms shared by both pixel lanes
   typedef struct packed {
      logic [TERM_W-1:0] red;
      logic [TERM_W-1:0] green;
      logic [TERM_W-1:0] blue;
   } chroma_type;

   // One RGB pixel
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

endpackage

// File: src/yrc_chroma.sv
// Chroma unit: U/V products (stage 1) and floored per-channel chroma terms (stage 2).
module yrc_chroma (
   input  logic                 clock,
   input  logic [7:0]           u_byte,
   input  logic [7:0]           v_byte,
   output yrc_pkg::chroma_type  chroma
);

   logic signed [8:0] u_diff;
   logic signed [8:0] v_diff;

   logic signed [yrc_pkg::PROD_W-1:0] rv_prod_in, gv_prod_in, gu_prod_in, bu_prod_in;
   logic signed [yrc_pkg::PROD_W-1:0] rv_prod_ff, gv_prod_ff, gu_prod_ff, bu_prod_ff;
   logic signed [yrc_pkg::PROD_W-1:0] g_sum;
   yrc_pkg::chroma_type               chroma_in;
   yrc_pkg::chroma_type               chroma_ff;

   // Stage 1: offset removal and coefficient products
   assign u_diff = $signed({1'b0, u_byte}) - yrc_pkg::C_OFFSET;
   assign v_diff = $signed({1'b0, v_byte}) - yrc_pkg::C_OFFSET;

   assign rv_prod_in = yrc_pkg::K_RV * yrc_pkg::PROD_W'(v_diff);
   assign gv_prod_in = yrc_pkg::K_GV * yrc_pkg::PROD_W'(v_diff);
   assign gu_prod_in = yrc_pkg::K_GU * yrc_pkg::PROD_W'(u_diff);
   assign bu_prod_in = yrc_pkg::K_BU * yrc_pkg::PROD_W'(u_diff);

   always_ff @(posedge clock) begin
      rv_prod_ff <= rv_prod_in;
      gv_prod_ff <= gv_prod_in;
      gu_prod_ff <= gu_prod_in;
      bu_prod_ff <= bu_prod_in;
   end

   // Stage 2: green sum, then each term floored at zero on its own
   assign g_sum = gv_prod_ff + gu_prod_ff;

   always_comb begin
      chroma_in.red   = rv_prod_ff[yrc_pkg::PROD_W-1] ? '0 : rv_prod_ff[yrc_pkg::TERM_W-1:0];
      chroma_in.green = g_sum[yrc_pkg::PROD_W-1]      ? '0 : g_sum[yrc_pkg::TERM_W-1:0];
      chroma_in.blue  = bu_prod_ff[yrc_pkg::PROD_W-1] ? '0 : bu_prod_ff[yrc_pkg::TERM_W-1:0];
   end

   always_ff @(posedge clock) begin
      chroma_ff <= chroma_in;
   end

   assign chroma = chroma_ff;

endmodule

// File: src/yrc_lane.sv
// Pixel lane: luma product, floor, and per-channel sum/shift/cap for one output pixel.
module yrc_lane (
   input  logic                 clock,
   input  logic [7:0]           y_byte,
   input  yrc_pkg::chroma_type  chroma,
   output yrc_pkg::pixel_type   pixel
);

   logic signed [8:0]                 y_diff;
   logic signed [yrc_pkg::PROD_W-1:0] luma_prod_in;
   logic signed [yrc_pkg::PROD_W-1:0] luma_prod_ff;
   logic [yrc_pkg::TERM_W-1:0]        luma_in;
   logic [yrc_pkg::TERM_W-1:0]        luma_ff;
   logic [yrc_pkg::SUM_W-1:0]         sum_r, sum_g, sum_b;
   yrc_pkg::pixel_type                pixel_in;
   yrc_pkg::pixel_type                pixel_ff;

   // Saturate the integer part of a channel sum to 8 bits
   function automatic logic [7:0] cap_channel(input logic [yrc_pkg::SUM_W-1:0] s);
      logic [yrc_pkg::SUM_W-yrc_pkg::FX_SHIFT-1:0] whole;
      whole = s[yrc_pkg::SUM_W-1:yrc_pkg::FX_SHIFT];
      return (whole > {2'b00, yrc_pkg::CH_MAX}) ? yrc_pkg::CH_MAX : whole[7:0];
   endfunction

   // Stage 1: luma product
   assign y_diff       = $signed({1'b0, y_byte}) - yrc_pkg::Y_OFFSET;
   assign luma_prod_in = yrc_pkg::K_Y * yrc_pkg::PROD_W'(y_diff);

   always_ff @(posedge clock) begin
      luma_prod_ff <= luma_prod_in;
   end

   // Stage 2: floor at zero
   assign luma_in = luma_prod_ff[yrc_pkg::PROD_W-1] ? '0 : luma_prod_ff[yrc_pkg::TERM_W-1:0];

   always_ff @(posedge clock) begin
      luma_ff <= luma_in;
   end

   // Stage 3: add chroma, drop the fraction, cap
   assign sum_r = {1'b0, luma_ff} + {1'b0, chroma.red};
   assign sum_g = {1'b0, luma_ff} + {1'b0, chroma.green};
   assign sum_b = {1'b0, luma_ff} + {1'b0, chroma.blue};

   always_comb begin
      pixel_in.red   = cap_channel(sum_r);
      pixel_in.green = cap_channel(sum_g);
      pixel_in.blue  = cap_channel(sum_b);
   end

   always_ff @(posedge clock) begin
      pixel_ff <= pixel_in;
   end

   assign pixel = pixel_ff;

endmodule

// File: src/yuv422_to_rgb888_convert.sv
// Top level: YUV 4:2:2 macropixel to two RGB888 pixels, BT.601 video range.
//
// One macropixel item is taken in every clock (busy is always low) and its two
// RGB pixels appear on rsp_data with rsp_valid high for one cycle only; the
// receiver must take them then. The three-stage multiply / floor /
// sum-and-cap pipeline runs two luma lanes beside one shared chroma unit.
// csr_write_data, written on csr_write_en, selects the byte packing (YUYV,
// UYVY, VYUY, YVYU, UVY2, VUY2, Y2UV, Y2VU) used when an item is accepted,
// so change it only while no items are in flight.
module yuv422_to_rgb888_convert (
   input  logic              clock,
   input  logic              reset,
   // item input
   input  logic              start,
   output logic              busy,
   input  yrc_pkg::req_type  req_data,
   // result output
   output logic              rsp_valid,
   output yrc_pkg::rsp_type  rsp_data,
   // byte order register
   input  logic              csr_write_en,
   input  logic [2:0]        csr_write_data
);

   localparam int STAGES = 3;

   yrc_pkg::byte_order_type byte_order_ff;
   yrc_pkg::pick_type       pick;
   logic [3:0][7:0]         bytes;
   logic [7:0]              y0_byte, y1_byte, u_byte, v_byte;
   logic [STAGES-1:0]       valid_ff;
   logic [STAGES-1:0]       valid_in;
   logic [STAGES-1:0]       frame_end_ff;
   logic [STAGES-1:0]       frame_end_in;
   yrc_pkg::chroma_type     chroma;
   yrc_pkg::pixel_type      pixel_first;
   yrc_pkg::pixel_type      pixel_second;
   logic                    accept;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // Byte order register
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_order_ff <= yrc_pkg::ORDER_YUYV;
      end else if (csr_write_en) begin
         byte_order_ff <= yrc_pkg::byte_order_type'(csr_write_data);
      end
   end

   // Unpack Y0, Y1, U, V according to the packing
   assign bytes = {req_data.byte_3, req_data.byte_2, req_data.byte_1, req_data.byte_0};
   assign pick  = yrc_pkg::pick_lookup(byte_order_ff);

   assign y0_byte = bytes[pick.pos_y0];
   assign y1_byte = bytes[pick.pos_y1];
   assign u_byte  = bytes[pick.pos_u];
   assign v_byte  = bytes[pick.pos_v];

   // Shared chroma terms
   yrc_chroma u_chroma (
      .clock  (clock),
      .u_byte (u_byte),
      .v_byte (v_byte),
      .chroma (chroma)
   );

   // One lane per output pixel
   yrc_lane u_lane_first (
      .clock  (clock),
      .y_byte (y0_byte),
      .chroma (chroma),
      .pixel  (pixel_first)
   );

   yrc_lane u_lane_second (
      .clock  (clock),
      .y_byte (y1_byte),
      .chroma (chroma),
      .pixel  (pixel_second)
   );

   // Item valid and end-of-frame flag follow the lanes
   assign valid_in     = {valid_ff[STAGES-2:0], accept};
   assign frame_end_in = {frame_end_ff[STAGES-2:0], req_data.frame_end_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_end_ff <= frame_end_in;
   end

   // Merge the two lanes into one result item
   always_comb begin
      rsp_data.red_first     = pixel_first.red;
      rsp_data.green_first   = pixel_first.green;
      rsp_data.blue_first    = pixel_first.blue;
      rsp_data.red_second    = pixel_second.red;
      rsp_data.green_second  = pixel_second.green;
      rsp_data.blue_second   = pixel_second.blue;
      rsp_data.frame_end_out = frame_end_ff[STAGES-1];
   end

   assign rsp_valid = valid_ff[STAGES-1];

endmodule

// File: sim/tb_yuv422_to_rgb888_convert.sv
// Testbench for the YUV 4:2:2 to RGB888 converter: directed and random macropixels, scoreboard.
module tb_yuv422_to_rgb888_convert;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PIPE_DEPTH   = 3;
   localparam int RANDOM_ITEMS = 450;
   localparam int IDLE_PCT     = 21;

   // Expected pixel pairs, predicted from each accepted macropixel
   class rgb_scoreboard;
      yrc_pkg::byte_order_type order;
      yrc_pkg::rsp_type        pixel_queue[$];
      int unsigned             mismatches;
      int unsigned             checked;

      function new();
         order      = yrc_pkg::ORDER_YUYV;
         mismatches = 0;
         checked    = 0;
      endfunction

      function void set_order(logic [2:0] value);
         order = yrc_pkg::byte_order_type'(value);
      endfunction

      function int pending();
         return pixel_queue.size();
      endfunction

      // Sum, drop the 20 fraction bits, cap at 255
      function logic [7:0] to_channel(longint luma, longint chroma);
         longint sum;
         sum = (luma + chroma) >>> 20;
         return (sum > 255) ? 8'd255 : sum[7:0];
      endfunction

      function void note_item(yrc_pkg::req_type item);
         logic [7:0]       b [4];
         int               py0, py1, pu, pv;
         longint           y0, y1, u, v, l0, l1, cr, cg, cb;
         yrc_pkg::rsp_type want;
         b[0] = item.byte_0;
         b[1] = item.byte_1;
         b[2] = item.byte_2;
         b[3] = item.byte_3;
         // byte positions of Y0, Y1, U, V for the current packing
         case (order)
            yrc_pkg::ORDER_YUYV: begin py0 = 0; py1 = 2; pu = 1; pv = 3; end
            yrc_pkg::ORDER_UYVY: begin py0 = 1; py1 = 3; pu = 0; pv = 2; end
            yrc_pkg::ORDER_VYUY: begin py0 = 1; py1 = 3; pu = 2; pv = 0; end
            yrc_pkg::ORDER_YVYU: begin py0 = 0; py1 = 2; pu = 3; pv = 1; end
            yrc_pkg::ORDER_UVY2: begin py0 = 3; py1 = 1; pu = 0; pv = 2; end
            yrc_pkg::ORDER_VUY2: begin py0 = 3; py1 = 1; pu = 2; pv = 0; end
            yrc_pkg::ORDER_Y2UV: begin py0 = 2; py1 = 0; pu = 1; pv = 3; end
            default:             begin py0 = 2; py1 = 0; pu = 3; pv = 1; end
         endcase
         y0 = longint'(b[py0]);
         y1 = longint'(b[py1]);
         u  = longint'(b[pu]) - 128;
         v  = longint'(b[pv]) - 128;
         // each term floored at zero on its own
         l0 = (y0 - 16) * 1220542;
         l1 = (y1 - 16) * 1220542;
         cr = 1673527 * v;
         cg = -852492 * v - 409993 * u;
         cb = 2116026 * u;
         if (l0 < 0) l0 = 0;
         if (l1 < 0) l1 = 0;
         if (cr < 0) cr = 0;
         if (cg < 0) cg = 0;
         if (cb < 0) cb = 0;
         want.red_first     = to_channel(l0, cr);
         want.green_first   = to_channel(l0, cg);
         want.blue_first    = to_channel(l0, cb);
         want.red_second    = to_channel(l1, cr);
         want.green_second  = to_channel(l1, cg);
         want.blue_second   = to_channel(l1, cb);
         want.frame_end_out = item.frame_end_in;
         pixel_queue.push_back(want);
      endfunction

      function void check_pixels(yrc_pkg::rsp_type got);
         yrc_pkg::rsp_type want;
         if (pixel_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: pixel pair with nothing pending: %h", got);
            return;
         end
         want = pixel_queue.pop_front();
         checked++;
         if (got.red_first !== want.red_first || got.green_first !== want.green_first ||
             got.blue_first !== want.blue_first || got.red_second !== want.red_second ||
             got.green_second !== want.green_second ||
             got.blue_second !== want.blue_second ||
             got.frame_end_out !== want.frame_end_out) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"ERROR: item %0d: expected %h %h %h / %h %h %h fe %b,",
                         " got %h %h %h / %h %h %h fe %b"}, checked,
                        want.red_first, want.green_first, want.blue_first,
                        want.red_second, want.green_second, want.blue_second,
                        want.frame_end_out,
                        got.red_first, got.green_first, got.blue_first,
                        got.red_second, got.green_second, got.blue_second,
                        got.frame_end_out);
         end
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset;
   logic             start;
   logic             busy;
   yrc_pkg::req_type req_data;
   logic             rsp_valid;
   yrc_pkg::rsp_type rsp_data;
   logic             csr_write_en;
   logic [2:0]       csr_write_data;

   rgb_scoreboard sb;
   bit            gaps_on;
   logic [7:0]    orders_seen;

   yuv422_to_rgb888_convert dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Sample both channels and the register port at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            sb.check_pixels(rsp_data);
         if (start && !busy)
            sb.note_item(req_data);
         if (csr_write_en) begin
            sb.set_order(csr_write_data);
            orders_seen[csr_write_data] = 1'b1;
         end
      end
   end

   function automatic yrc_pkg::req_type make_item(logic [7:0] b0, logic [7:0] b1,
                                                  logic [7:0] b2, logic [7:0] b3,
                                                  logic fe);
      yrc_pkg::req_type item;
      item.byte_0       = b0;
      item.byte_1       = b1;
      item.byte_2       = b2;
      item.byte_3       = b3;
      item.frame_end_in = fe;
      return item;
   endfunction

   // Mostly uniform bytes, with a share of range corners and offset edges
   function automatic logic [7:0] pick_byte();
      if ($urandom_range(3) != 0)
         return 8'($urandom);
      case ($urandom_range(9))
         0: return 8'd0;
         1: return 8'd1;
         2: return 8'd15;
         3: return 8'd16;
         4: return 8'd17;
         5: return 8'd127;
         6: return 8'd128;
         7: return 8'd129;
         8: return 8'd235;
         default: return 8'd255;
      endcase
   endfunction

   function automatic yrc_pkg::req_type random_macropixel();
      return make_item(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                       $urandom_range(15) == 0);
   endfunction

   // Present one item from a falling edge, with random idle cycles ahead of it when gaps_on is set
   task automatic send_item(input yrc_pkg::req_type item);
      if (gaps_on) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            start    = 1'b0;
            req_data = {$urandom, 1'($urandom)};
            @(negedge clock);
         end
      end
      start    = 1'b1;
      req_data = item;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // Hold off until every pending pixel pair is back, then let the pipe settle
   task automatic drain();
      start = 1'b0;
      while (sb.pending() != 0)
         @(negedge clock);
      repeat (PIPE_DEPTH + 1) @(negedge clock);
   endtask

   task automatic write_order(input yrc_pkg::byte_order_type ord);
      csr_write_en   = 1'b1;
      csr_write_data = ord;
      @(negedge clock);
      csr_write_en   = 1'b0;
      csr_write_data = 3'($urandom);
   endtask

   // Directed corners, all packings, then random phases
   initial begin
      yrc_pkg::byte_order_type ord;
      yrc_pkg::byte_order_type sweep [8];
      int                      sent;
      int                      phase;
      int                      count;
      sb             = new();
      gaps_on        = 1'b1;
      orders_seen    = '0;
      reset          = 1'b1;
      start          = 1'b0;
      req_data       = '0;
      csr_write_en   = 1'b0;
      csr_write_data = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // reset packing (YUYV): black, white, luma floor, chroma floors
      send_item(make_item(8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
      send_item(make_item(8'd255, 8'd255, 8'd255, 8'd255, 1'b1));
      send_item(make_item(8'd16, 8'd128, 8'd16, 8'd128, 1'b0));
      send_item(make_item(8'd235, 8'd128, 8'd235, 8'd128, 1'b0));
      send_item(make_item(8'd15, 8'd128, 8'd17, 8'd128, 1'b0));
      send_item(make_item(8'd128, 8'd0, 8'd128, 8'd0, 1'b0));
      send_item(make_item(8'd128, 8'd255, 8'd128, 8'd255, 1'b0));
      send_item(make_item(8'd255, 8'd0, 8'd0, 8'd255, 1'b0));
      send_item(make_item(8'd200, 8'd255, 8'd50, 8'd0, 1'b0));
      send_item(make_item(8'd0, 8'd255, 8'd255, 8'd0, 1'b1));

      // every packing, with distinct bytes so a wrong position shows
      sweep = '{yrc_pkg::ORDER_Y2VU, yrc_pkg::ORDER_UYVY, yrc_pkg::ORDER_VYUY,
                yrc_pkg::ORDER_YVYU, yrc_pkg::ORDER_UVY2, yrc_pkg::ORDER_VUY2,
                yrc_pkg::ORDER_Y2UV, yrc_pkg::ORDER_YUYV};
      foreach (sweep[i]) begin
         drain();
         write_order(sweep[i]);
         send_item(make_item(8'd16, 8'd128, 8'd235, 8'd60, 1'b0));
         send_item(make_item(8'd240, 8'd30, 8'd90, 8'd200, 1'b1));
      end

      // random phases, each under one packing
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         drain();
         ord = (phase == 0) ? yrc_pkg::ORDER_Y2VU
                            : yrc_pkg::byte_order_type'($urandom_range(7));
         write_order(ord);
         gaps_on = (phase != 2);
         count   = $urandom_range(30, 80);
         for (int k = 0; k < count && sent < RANDOM_ITEMS; k++) begin
            // one full stop mid-phase now and then
            if (k == count / 2 && phase % 3 == 1)
               drain();
            send_item(random_macropixel());
            sent++;
         end
         phase++;
      end
      gaps_on = 1'b1;

      drain();
      repeat (8) @(negedge clock);
      $display("Summary: %0d pixel pairs checked over %0d random phases, packings written %b",
               sb.checked, phase, orders_seen);
      $display("Summary: %0d mismatches, %0d pixel pairs still pending",
               sb.mismatches, sb.pending());
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Hard stop well past the slowest legal run
   initial begin
      #2000000;
      $display("Timeout waiting for pixel pairs");
      $display("FAILED: results differ");
      $finish;
   end

endmodule
